FILE: rtl/core/klbs_pkg.sv
// Shared types, constants and classification functions for the keyword lexer.
package klbs_pkg;

	localparam int MaxLexeme    = 255;
	localparam int KeywordChars = 9;
	localparam int PositionBits = 24;
	localparam int QueueDepth   = 4;

	// Token classes used by the scanner.
	localparam logic [5:0] T_DOT     = 6'd5;
	localparam logic [5:0] T_IDENT   = 6'd18;
	localparam logic [5:0] T_STRING  = 6'd19;
	localparam logic [5:0] T_NUM     = 6'd20;
	localparam logic [5:0] T_YES     = 6'd21;
	localparam logic [5:0] T_COMMENT = 6'd32;
	localparam logic [5:0] T_ACTION  = 6'd33;
	localparam logic [5:0] T_TEXT    = 6'd37;
	localparam logic [5:0] T_NUMBER  = 6'd38;
	localparam logic [5:0] T_YESNO   = 6'd39;
	localparam logic [5:0] T_VAR     = 6'd41;
	localparam logic [5:0] T_FUNC    = 6'd42;
	localparam logic [5:0] T_END     = 6'd44;

	localparam logic [1:0] E_NONE    = 2'd0;
	localparam logic [1:0] E_UNKNOWN = 2'd1;
	localparam logic [1:0] E_UNTERM  = 2'd2;
	localparam logic [1:0] E_LONG    = 2'd3;

	// Scanner modes, one-hot.
	typedef enum logic [9:0] {
		M_IDLE    = 10'b0000000001,
		M_OP      = 10'b0000000010,
		M_IDENT   = 10'b0000000100,
		M_INT     = 10'b0000001000,
		M_DOT     = 10'b0000010000,
		M_FRAC    = 10'b0000100000,
		M_STR     = 10'b0001000000,
		M_COMMENT = 10'b0010000000,
		M_NSKIP   = 10'b0100000000,
		M_NAME    = 10'b1000000000
	} mode_t;

	// One token as it travels through the queue.
	typedef struct packed {
		logic [5:0]  token_type;
		logic [23:0] line_no;
		logic [23:0] start_pos;
		logic [7:0]  lexeme_len;
		logic        yes_value;
		logic [1:0]  error_code;
		logic        last_of_run;
	} token_t;

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) || c == 8'h5F;
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic logic is_word(input logic [7:0] c);
		return is_alpha(c) || is_digit(c);
	endfunction

	// Operator class; dbl selects the two-character form.
	function automatic logic [5:0] op_type(input logic [7:0] op, input logic dbl);
		logic [5:0] t;
		case (op)
			8'h21:   t = 6'd10;
			8'h3E:   t = 6'd11;
			8'h3C:   t = 6'd12;
			default: t = 6'd13;
		endcase
		return dbl ? t + 6'd4 : t;
	endfunction

	// Single-character punctuation; bit 6 flags a match.
	function automatic logic [6:0] punct(input logic [7:0] c);
		logic [6:0] r;
		case (c)
			8'h5B:   r = {1'b1, 6'd0};
			8'h5D:   r = {1'b1, 6'd1};
			8'h28:   r = {1'b1, 6'd2};
			8'h29:   r = {1'b1, 6'd3};
			8'h2C:   r = {1'b1, 6'd4};
			8'h2E:   r = {1'b1, 6'd5};
			8'h2B:   r = {1'b1, 6'd6};
			8'h2D:   r = {1'b1, 6'd7};
			8'h2A:   r = {1'b1, 6'd8};
			8'h2F:   r = {1'b1, 6'd9};
			default: r = 7'd0;
		endcase
		return r;
	endfunction

endpackage

FILE: rtl/core/klbs_kwmatch.sv
// Parallel keyword table compare for a finished identifier.
module klbs_kwmatch #(
	parameter int KEYWORD_CHARS = klbs_pkg::KeywordChars
) (
	input  logic [KEYWORD_CHARS*8-1:0] chars,
	input  logic [7:0]                 len,
	output logic [5:0]                 token_type
);

	localparam int KwMax = 9;
	localparam int Nkw   = 21;

	typedef struct packed {
		logic [KwMax*8-1:0] word;
		logic [3:0]         wlen;
		logic [5:0]         ttype;
	} kw_t;

	// Words are packed with the first character in the low byte.
	function automatic logic [KwMax*8-1:0] pk(input logic [KwMax*8-1:0] s, input int n);
		logic [KwMax*8-1:0] r;
		r = '0;
		for (int i = 0; i < KwMax; i++) begin
			if (i < n) begin
				r[i*8 +: 8] = s[(n-1-i)*8 +: 8];
			end
		end
		return r;
	endfunction

	function automatic kw_t kw(input int idx);
		kw_t k;
		case (idx)
			0:  k = '{pk("yes", 3), 4'd3, 6'd21};
			1:  k = '{pk("no", 2), 4'd2, 6'd22};
			2:  k = '{pk("if", 2), 4'd2, 6'd36};
			3:  k = '{pk("and", 3), 4'd3, 6'd23};
			4:  k = '{pk("text", 4), 4'd4, 6'd37};
			5:  k = '{pk("number", 6), 4'd6, 6'd38};
			6:  k = '{pk("yesno", 5), 4'd5, 6'd39};
			7:  k = '{pk("list", 4), 4'd4, 6'd40};
			8:  k = '{pk("have", 4), 4'd4, 6'd35};
			9:  k = '{pk("give", 4), 4'd4, 6'd34};
			10: k = '{pk("action", 6), 4'd6, 6'd33};
			11: k = '{pk("comment", 7), 4'd7, 6'd32};
			12: k = '{pk("say", 3), 4'd3, 6'd31};
			13: k = '{pk("nothing", 7), 4'd7, 6'd30};
			14: k = '{pk("for", 3), 4'd3, 6'd29};
			15: k = '{pk("until", 5), 4'd5, 6'd28};
			16: k = '{pk("repeat", 6), 4'd6, 6'd27};
			17: k = '{pk("otherwise", 9), 4'd9, 6'd26};
			18: k = '{pk("or", 2), 4'd2, 6'd24};
			19: k = '{pk("not", 3), 4'd3, 6'd25};
			default: k = '{pk("is", 2), 4'd2, 6'd43};
		endcase
		return k;
	endfunction

	// Every entry compares at once; the entries never overlap.
	always_comb begin
		kw_t k;
		logic hit;
		token_type = klbs_pkg::T_IDENT;
		for (int i = 0; i < Nkw; i++) begin
			k = kw(i);
			hit = (len == 8'(k.wlen));
			for (int j = 0; j < KwMax; j++) begin
				if (j < int'(k.wlen)) begin
					hit = hit && (chars[j*8 +: 8] == k.word[j*8 +: 8]);
				end
			end
			if (hit) begin
				token_type = k.ttype;
			end
		end
	end

endmodule

FILE: rtl/core/klbs_front.sv
// Scanner: accepts source words and produces up to three tokens per word.
module klbs_front #(
	parameter int MAX_LEXEME    = klbs_pkg::MaxLexeme,
	parameter int KEYWORD_CHARS = klbs_pkg::KeywordChars,
	parameter int POSITION_BITS = klbs_pkg::PositionBits
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                kind,
	input  logic [7:0]          byte_in,
	output logic [1:0]          tok_cnt,
	output klbs_pkg::token_t    tok0,
	output klbs_pkg::token_t    tok1,
	output klbs_pkg::token_t    tok2
);

	localparam logic [POSITION_BITS-1:0] PosMax = '1;
	localparam logic [23:0]              LineTop = '1;

	klbs_pkg::mode_t            mode_q, nmode;
	logic [7:0]                 pend_q, npend;
	logic [KEYWORD_CHARS*8-1:0] kbuf_q, nkbuf;
	logic [7:0]                 len_q, nlen;
	logic [POSITION_BITS-1:0]   start_q, nstart;
	logic [POSITION_BITS-1:0]   pos_q;
	logic [23:0]                line_q, nline;
	logic                       nkind_q, nnkind;
	logic                       halt_q, nhalt;
	logic [5:0]                 kw_type;

	klbs_kwmatch #(.KEYWORD_CHARS(KEYWORD_CHARS)) u_kw (
		.chars(kbuf_q), .len(len_q), .token_type(kw_type)
	);

	function automatic klbs_pkg::token_t mk(input logic [5:0] t, input logic [23:0] ln,
		input logic [POSITION_BITS-1:0] s, input logic [7:0] l, input logic [1:0] e);
		klbs_pkg::token_t r;
		r.token_type  = t;
		r.line_no     = ln;
		r.start_pos   = 24'(s);
		r.lexeme_len  = l;
		r.yes_value   = (t == klbs_pkg::T_YES) && (e == klbs_pkg::E_NONE);
		r.error_code  = e;
		r.last_of_run = 1'b0;
		return r;
	endfunction

	// Scan one word: a pass through the current mode, then at most a rescan in idle.
	always_comb begin
		logic                     e;
		logic [7:0]               c;
		logic                     again;
		logic [6:0]               pu;
		logic [POSITION_BITS:0]   dsum;
		klbs_pkg::token_t         tk [3];
		logic [1:0]               n;
		logic [5:0]               nt;
		e = kind;
		c = byte_in;
		nmode = mode_q; npend = pend_q; nkbuf = kbuf_q; nlen = len_q;
		nstart = start_q; nline = line_q; nnkind = nkind_q; nhalt = halt_q;
		n = 2'd0;
		again = 1'b0;
		pu = klbs_pkg::punct(c);
		dsum = {1'b0, start_q} + (POSITION_BITS+1)'(len_q);
		nt = nkind_q ? klbs_pkg::T_FUNC : klbs_pkg::T_VAR;
		for (int i = 0; i < 3; i++) begin
			tk[i] = '0;
		end
		// First pass in the current mode.
		unique case (mode_q)
			klbs_pkg::M_IDLE: again = 1'b1;
			klbs_pkg::M_OP: begin
				nmode = klbs_pkg::M_IDLE;
				if (!e && c == 8'h3D) begin
					tk[n] = mk(klbs_pkg::op_type(pend_q, 1'b1), nline, start_q, 8'd2,
						klbs_pkg::E_NONE);
					n = n + 2'd1;
				end else begin
					tk[n] = mk(klbs_pkg::op_type(pend_q, 1'b0), nline, start_q, 8'd1,
						klbs_pkg::E_NONE);
					n = n + 2'd1;
					again = 1'b1;
				end
			end
			klbs_pkg::M_IDENT: begin
				if (!e && klbs_pkg::is_word(c)) begin
					if (int'(len_q) + 1 > MAX_LEXEME) begin
						tk[n] = mk(6'd0, nline, start_q, 8'd0, klbs_pkg::E_LONG);
						n = n + 2'd1; nhalt = 1'b1;
					end else begin
						for (int j = 0; j < KEYWORD_CHARS; j++) begin
							if (int'(len_q) == j) nkbuf[j*8 +: 8] = c;
						end
						nlen = len_q + 8'd1;
					end
				end else begin
					nmode = klbs_pkg::M_IDLE;
					if (int'(len_q) <= KEYWORD_CHARS && kw_type == klbs_pkg::T_COMMENT) begin
						nmode = klbs_pkg::M_COMMENT;
						if (e || c == 8'h0A) nmode = klbs_pkg::M_IDLE;
						else again = 1'b0;
						again = e || c == 8'h0A;
					end else begin
						logic [5:0] ty;
						ty = (int'(len_q) <= KEYWORD_CHARS) ? kw_type : klbs_pkg::T_IDENT;
						tk[n] = mk(ty, nline, start_q, len_q, klbs_pkg::E_NONE);
						n = n + 2'd1;
						if (ty == klbs_pkg::T_NUMBER || ty == klbs_pkg::T_TEXT ||
							ty == klbs_pkg::T_YESNO || ty == klbs_pkg::T_ACTION) begin
							nnkind = (ty == klbs_pkg::T_ACTION);
							nt = nnkind ? klbs_pkg::T_FUNC : klbs_pkg::T_VAR;
							// Name skip handled right here, then rescan in idle if needed.
							if (!e && c == 8'h20) begin
								nmode = klbs_pkg::M_NSKIP;
							end else if (!e && klbs_pkg::is_word(c)) begin
								nmode = klbs_pkg::M_NAME; nstart = pos_q; nlen = 8'd1;
							end else begin
								tk[n] = mk(nt, nline, pos_q, 8'd0, klbs_pkg::E_NONE);
								n = n + 2'd1;
								again = 1'b1;
							end
						end else begin
							again = 1'b1;
						end
					end
				end
			end
			klbs_pkg::M_INT: begin
				if (!e && klbs_pkg::is_digit(c)) begin
					if (int'(len_q) + 1 > MAX_LEXEME) begin
						tk[n] = mk(6'd0, nline, start_q, 8'd0, klbs_pkg::E_LONG);
						n = n + 2'd1; nhalt = 1'b1;
					end else nlen = len_q + 8'd1;
				end else if (!e && c == 8'h2E) begin
					nmode = klbs_pkg::M_DOT;
				end else begin
					tk[n] = mk(klbs_pkg::T_NUM, nline, start_q, len_q, klbs_pkg::E_NONE);
					n = n + 2'd1; nmode = klbs_pkg::M_IDLE; again = 1'b1;
				end
			end
			klbs_pkg::M_DOT: begin
				if (!e && klbs_pkg::is_digit(c)) begin
					if (int'(len_q) + 2 > MAX_LEXEME) begin
						tk[n] = mk(6'd0, nline, start_q, 8'd0, klbs_pkg::E_LONG);
						n = n + 2'd1; nhalt = 1'b1;
					end else begin
						nlen = len_q + 8'd2; nmode = klbs_pkg::M_FRAC;
					end
				end else begin
					tk[n] = mk(klbs_pkg::T_NUM, nline, start_q, len_q, klbs_pkg::E_NONE);
					n = n + 2'd1;
					tk[n] = mk(klbs_pkg::T_DOT, nline,
						(dsum > {1'b0, PosMax}) ? PosMax : dsum[POSITION_BITS-1:0],
						8'd1, klbs_pkg::E_NONE);
					n = n + 2'd1; nmode = klbs_pkg::M_IDLE; again = 1'b1;
				end
			end
			klbs_pkg::M_FRAC: begin
				if (!e && klbs_pkg::is_digit(c)) begin
					if (int'(len_q) + 1 > MAX_LEXEME) begin
						tk[n] = mk(6'd0, nline, start_q, 8'd0, klbs_pkg::E_LONG);
						n = n + 2'd1; nhalt = 1'b1;
					end else nlen = len_q + 8'd1;
				end else begin
					tk[n] = mk(klbs_pkg::T_NUM, nline, start_q, len_q, klbs_pkg::E_NONE);
					n = n + 2'd1; nmode = klbs_pkg::M_IDLE; again = 1'b1;
				end
			end
			klbs_pkg::M_STR: begin
				if (e) begin
					tk[n] = mk(6'd0, nline, start_q, 8'd0, klbs_pkg::E_UNTERM);
					n = n + 2'd1; nhalt = 1'b1;
				end else if (int'(len_q) + 1 > MAX_LEXEME) begin
					tk[n] = mk(6'd0, nline, start_q, 8'd0, klbs_pkg::E_LONG);
					n = n + 2'd1; nhalt = 1'b1;
				end else begin
					nlen = len_q + 8'd1;
					if (c == 8'h22) begin
						tk[n] = mk(klbs_pkg::T_STRING, nline, start_q, nlen, klbs_pkg::E_NONE);
						n = n + 2'd1; nmode = klbs_pkg::M_IDLE;
					end else if (c == 8'h0A && line_q < LineTop) begin
						nline = line_q + 24'd1;
					end
				end
			end
			klbs_pkg::M_COMMENT: begin
				if (e || c == 8'h0A) begin
					nmode = klbs_pkg::M_IDLE; again = 1'b1;
				end
			end
			klbs_pkg::M_NSKIP: begin
				if (!e && c == 8'h20) begin
					nmode = klbs_pkg::M_NSKIP;
				end else if (!e && klbs_pkg::is_word(c)) begin
					nstart = pos_q; nlen = 8'd1; nmode = klbs_pkg::M_NAME;
				end else begin
					tk[n] = mk(nt, nline, pos_q, 8'd0, klbs_pkg::E_NONE);
					n = n + 2'd1; nmode = klbs_pkg::M_IDLE; again = 1'b1;
				end
			end
			klbs_pkg::M_NAME: begin
				if (!e && klbs_pkg::is_word(c)) begin
					if (int'(len_q) + 1 > MAX_LEXEME) begin
						tk[n] = mk(6'd0, nline, start_q, 8'd0, klbs_pkg::E_LONG);
						n = n + 2'd1; nhalt = 1'b1;
					end else nlen = len_q + 8'd1;
				end else begin
					tk[n] = mk(nt, nline, start_q, len_q, klbs_pkg::E_NONE);
					n = n + 2'd1; nmode = klbs_pkg::M_IDLE; again = 1'b1;
				end
			end
			default: again = 1'b1;
		endcase
		// Rescan in idle.
		if (again && !nhalt) begin
			nmode = klbs_pkg::M_IDLE;
			if (e) begin
				tk[n] = mk(klbs_pkg::T_END, nline, pos_q, 8'd0, klbs_pkg::E_NONE);
				n = n + 2'd1; nhalt = 1'b1;
			end else if (pu[6]) begin
				tk[n] = mk(pu[5:0], nline, pos_q, 8'd1, klbs_pkg::E_NONE);
				n = n + 2'd1;
			end else if (c == 8'h21 || c == 8'h3C || c == 8'h3E || c == 8'h3D) begin
				npend = c; nstart = pos_q; nmode = klbs_pkg::M_OP;
			end else if (c == 8'h20 || c == 8'h09 || c == 8'h0D) begin
				nmode = klbs_pkg::M_IDLE;
			end else if (c == 8'h0A) begin
				if (nline < LineTop) nline = nline + 24'd1;
			end else if (c == 8'h22) begin
				nstart = pos_q; nlen = 8'd1; nmode = klbs_pkg::M_STR;
			end else if (klbs_pkg::is_alpha(c)) begin
				nstart = pos_q; nlen = 8'd1; nkbuf[7:0] = c; nmode = klbs_pkg::M_IDENT;
			end else if (klbs_pkg::is_digit(c)) begin
				nstart = pos_q; nlen = 8'd1; nmode = klbs_pkg::M_INT;
			end else begin
				tk[n] = mk(6'd0, nline, pos_q, 8'd0, klbs_pkg::E_UNKNOWN);
				n = n + 2'd1; nhalt = 1'b1;
			end
		end
		if (halt_q) n = 2'd0;
		if (n != 2'd0) tk[n - 2'd1].last_of_run = 1'b1;
		tok_cnt = n;
		tok0 = tk[0];
		tok1 = tk[1];
		tok2 = tk[2];
	end

	// State update on an accepted word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= klbs_pkg::M_IDLE;
			pend_q  <= '0;
			len_q   <= '0;
			start_q <= '0;
			pos_q   <= '0;
			line_q  <= 24'd1;
			nkind_q <= 1'b0;
			halt_q  <= 1'b0;
		end else if (in_valid && !halt_q) begin
			mode_q  <= nmode;
			pend_q  <= npend;
			len_q   <= nlen;
			start_q <= nstart;
			line_q  <= nline;
			nkind_q <= nnkind;
			halt_q  <= nhalt;
			if (!kind && pos_q != PosMax) pos_q <= pos_q + 1'b1;
		end
	end

	// Keyword characters carry no reset.
	always_ff @(posedge clk) begin
		if (in_valid && !halt_q) kbuf_q <= nkbuf;
	end

endmodule

FILE: rtl/core/klbs_back.sv
// Token queue: takes up to three tokens a cycle and hands out one a cycle while popped and not empty.
module klbs_back #(
	parameter int DEPTH = klbs_pkg::QueueDepth
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [1:0]       wr_cnt,
	input  klbs_pkg::token_t t0,
	input  klbs_pkg::token_t t1,
	input  klbs_pkg::token_t t2,
	output logic             room,
	output logic             empty,
	input  logic             pop,
	output klbs_pkg::token_t head
);

	localparam int AW = $clog2(DEPTH);

	klbs_pkg::token_t   mem_q [DEPTH];
	logic [AW-1:0]      rd_q, wr_q;
	logic [AW:0]        cnt_q;
	logic               do_pop;
	logic [1:0]         nw;

	assign empty  = (cnt_q == '0);
	assign head   = mem_q[rd_q];
	assign do_pop = pop && !empty;
	assign nw     = wr_en ? wr_cnt : 2'd0;
	// Room for a full burst of three regardless of this cycle's pop.
	assign room   = (int'(cnt_q) + 3 <= DEPTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= '0;
			wr_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + AW'(nw);
			rd_q  <= rd_q + AW'(do_pop);
			cnt_q <= cnt_q + (AW+1)'(nw) - (AW+1)'(do_pop);
		end
	end

	// Token storage.
	always_ff @(posedge clk) begin
		if (nw > 2'd0) mem_q[wr_q] <= t0;
		if (nw > 2'd1) mem_q[wr_q + AW'(1)] <= t1;
		if (nw > 2'd2) mem_q[wr_q + AW'(2)] <= t2;
	end

endmodule

FILE: rtl/core/keyword_lexer_byte_stream_unit.sv
// Top level of the byte-stream keyword lexer.
// Usage: source words enter through push/full with kind (0 byte, 1 end of
// source) and byte_in. Tokens leave through empty/pop with token_type,
// line_no, start_pos, lexeme_len, yes_value, error_code and last_of_run.
// A word is scanned in the cycle it is accepted; the zero to three tokens it
// causes enter a four-entry queue and, if the queue was empty, the first is
// visible at its head the next cycle. Throughput is one byte per cycle while
// the queue drains one token per cycle; full rises whenever fewer than three
// queue entries are free, so a word is never taken without space for its
// tokens. last_of_run marks the final token caused by one word.
// After an error token or the end token the scanner halts: later words are
// accepted and produce nothing until reset.
// Reset (arst_n low) empties the queue, puts the scanner in idle, line 1,
// offset 0. When the receiver stops popping, the queue fills and full holds
// the source back; no token is lost.
module keyword_lexer_byte_stream_unit #(
	parameter int MAX_LEXEME    = klbs_pkg::MaxLexeme,
	parameter int KEYWORD_CHARS = klbs_pkg::KeywordChars,
	parameter int POSITION_BITS = klbs_pkg::PositionBits
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic        kind,
	input  logic [7:0]  byte_in,
	output logic        empty,
	input  logic        pop,
	output logic [5:0]  token_type,
	output logic [23:0] line_no,
	output logic [23:0] start_pos,
	output logic [7:0]  lexeme_len,
	output logic        yes_value,
	output logic [1:0]  error_code,
	output logic        last_of_run
);

	logic             room, acc;
	logic [1:0]       cnt;
	klbs_pkg::token_t t0, t1, t2, head;

	assign full = !room;
	assign acc  = push && room;

	klbs_front #(
		.MAX_LEXEME(MAX_LEXEME), .KEYWORD_CHARS(KEYWORD_CHARS), .POSITION_BITS(POSITION_BITS)
	) u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(acc), .kind(kind), .byte_in(byte_in),
		.tok_cnt(cnt), .tok0(t0), .tok1(t1), .tok2(t2)
	);

	klbs_back u_back (
		.clk(clk), .arst_n(arst_n), .wr_en(acc), .wr_cnt(cnt), .t0(t0), .t1(t1), .t2(t2),
		.room(room), .empty(empty), .pop(pop), .head(head)
	);

	// Result fields from the queue head.
	assign token_type  = head.token_type;
	assign line_no     = head.line_no;
	assign start_pos   = head.start_pos;
	assign lexeme_len  = head.lexeme_len;
	assign yes_value   = head.yes_value;
	assign error_code  = head.error_code;
	assign last_of_run = head.last_of_run;

endmodule
